// ----- rtl/core/utf8d_pkg.sv -----
// Shared types, codes and helper functions of the UTF-8 byte stream decoder.
package utf8d_pkg;

   localparam int unsigned CpWidth = 21;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       string_end;
   } utf8d_req_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               bad_sequence;
      logic               error_seen;
      logic               last_of_run;
      logic               final_of_string;
   } utf8d_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic rescan_step;
   } utf8d_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic need_rescan;
      logic rescan_last;
   } utf8d_status_type;

   typedef enum logic [1:0] {
      ST_ACCEPT = 2'b01,
      ST_RESCAN = 2'b10
   } utf8d_state_type;

   localparam logic [2:0] WidthBad = 3'd0;
   localparam logic [2:0] WidthOne = 3'd1;
   localparam logic [2:0] WidthTwo = 3'd2;
   localparam logic [2:0] WidthThree = 3'd3;
   localparam logic [2:0] WidthFour = 3'd4;

   // Sequence width from a head byte; zero marks a byte that cannot start one.
   function automatic logic [2:0] head_width(input logic [7:0] b);
      logic [2:0] w;
      begin
         if (b[7] == 1'b0) begin
            w = WidthOne;
         end else if (b[7:5] == 3'b110) begin
            w = WidthTwo;
         end else if (b[7:4] == 4'b1110) begin
            w = WidthThree;
         end else if (b[7:3] == 5'b11110) begin
            w = WidthFour;
         end else begin
            w = WidthBad;
         end
         return w;
      end
   endfunction

   // Payload bits of a head byte for a sequence of the given width.
   function automatic logic [CpWidth-1:0] head_bits(input logic [2:0] w, input logic [7:0] b);
      logic [CpWidth-1:0] v;
      begin
         case (w)
            WidthOne:   v = {14'd0, b[6:0]};
            WidthTwo:   v = {16'd0, b[4:0]};
            WidthThree: v = {17'd0, b[3:0]};
            WidthFour:  v = {18'd0, b[2:0]};
            default:    v = '0;
         endcase
         return v;
      end
   endfunction

   // Whole code point of a sequence of up to three bytes held side by side.
   function automatic logic [CpWidth-1:0] decode_held(input logic [2:0] w,
                                                       input logic [7:0] b0,
                                                       input logic [7:0] b1,
                                                       input logic [7:0] b2);
      logic [CpWidth-1:0] v;
      begin
         case (w)
            WidthOne:   v = {14'd0, b0[6:0]};
            WidthTwo:   v = {10'd0, b0[4:0], b1[5:0]};
            WidthThree: v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default:    v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

// ----- rtl/core/utf8d_ctrl.sv -----
// Controller state machine: takes bytes, and walks the rescan at string end.
module utf8d_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  utf8d_pkg::utf8d_status_type status,
   output utf8d_pkg::utf8d_cmd_type    cmd
);

   utf8d_pkg::utf8d_state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.accept      = 1'b0;
      cmd.rescan_step = 1'b0;
      req_stall       = 1'b1;
      case (state_ff)
         utf8d_pkg::ST_ACCEPT: begin
            req_stall  = !status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept && status.need_rescan) begin
               state_in = utf8d_pkg::ST_RESCAN;
            end
         end
         utf8d_pkg::ST_RESCAN: begin
            cmd.rescan_step = status.out_free;
            if (status.out_free && status.rescan_last) begin
               state_in = utf8d_pkg::ST_ACCEPT;
            end
         end
         default: begin
            state_in = utf8d_pkg::ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= utf8d_pkg::ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/utf8d_dp.sv -----
// Datapath: sequence gathering, held bytes, rescan decode and the output register.
module utf8d_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  utf8d_pkg::utf8d_req_type    req_payload,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output utf8d_pkg::utf8d_rsp_type    rsp_payload,
   input  utf8d_pkg::utf8d_cmd_type    cmd,
   output utf8d_pkg::utf8d_status_type status
);

   localparam int unsigned CpW = utf8d_pkg::CpWidth;

   logic [7:0]     pending_ff [3];
   logic [7:0]     pending_in [3];
   logic [1:0]     count_ff, count_in;
   logic [2:0]     exp_ff, exp_in;
   logic [CpW-1:0] partial_ff, partial_in;
   logic           sticky_ff, sticky_in;
   logic           rsp_valid_ff, rsp_valid_in;
   utf8d_pkg::utf8d_rsp_type rsp_payload_ff, rsp_payload_in;

   // Byte path.
   logic [7:0]     b;
   logic [2:0]     acc_w;
   logic           acc_emit;
   logic           acc_bad;
   logic [CpW-1:0] acc_cp;
   logic [1:0]     acc_count;
   logic [2:0]     acc_exp;
   logic [CpW-1:0] acc_partial;
   logic [CpW-1:0] shifted;
   logic           acc_store;
   logic           acc_rescan;

   // Rescan path.
   logic [2:0]     rs_w;
   logic           rs_fits;
   logic [1:0]     rs_used;
   logic [1:0]     rs_left;
   logic [CpW-1:0] rs_cp;

   assign b       = req_payload.byte_value;
   assign acc_w   = utf8d_pkg::head_width(b);
   assign shifted = {partial_ff[CpW-7:0], b[5:0]};

   always_comb begin
      acc_emit    = 1'b0;
      acc_bad     = 1'b0;
      acc_cp      = '0;
      acc_count   = count_ff;
      acc_exp     = exp_ff;
      acc_partial = partial_ff;
      acc_store   = 1'b0;
      if (count_ff == 2'd0) begin
         if (acc_w == utf8d_pkg::WidthBad) begin
            acc_emit = 1'b1;
            acc_bad  = 1'b1;
         end else if (acc_w == utf8d_pkg::WidthOne) begin
            acc_emit = 1'b1;
            acc_cp   = utf8d_pkg::head_bits(acc_w, b);
         end else begin
            acc_store   = 1'b1;
            acc_count   = 2'd1;
            acc_exp     = acc_w;
            acc_partial = utf8d_pkg::head_bits(acc_w, b);
         end
      end else begin
         if (({1'b0, count_ff} + 3'd1 >= exp_ff) || (count_ff == 2'd3)) begin
            acc_emit    = 1'b1;
            acc_cp      = shifted;
            acc_count   = 2'd0;
            acc_exp     = 3'd0;
            acc_partial = '0;
         end else begin
            acc_store   = 1'b1;
            acc_count   = count_ff + 2'd1;
            acc_partial = shifted;
         end
      end
      acc_rescan = req_payload.string_end && (acc_count != 2'd0);
   end

   // At the string end the held bytes are decoded again, one result a cycle
   // while the output is free, always from the front of the buffer, which then moves up.
   always_comb begin
      rs_w    = utf8d_pkg::head_width(pending_ff[0]);
      rs_fits = (rs_w != utf8d_pkg::WidthBad) && (rs_w <= {1'b0, count_ff});
      rs_used = rs_fits ? rs_w[1:0] : 2'd1;
      rs_left = count_ff - rs_used;
      rs_cp   = rs_fits ? utf8d_pkg::decode_held(rs_w, pending_ff[0], pending_ff[1],
                                                 pending_ff[2]) : '0;
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign status.need_rescan = acc_rescan;
   assign status.rescan_last = (rs_left == 2'd0);

   always_comb begin
      pending_in     = pending_ff;
      count_in       = count_ff;
      exp_in         = exp_ff;
      partial_in     = partial_ff;
      sticky_in      = sticky_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         if (acc_store && (count_ff != 2'd3)) begin
            pending_in[count_ff] = b;
         end
         count_in   = acc_count;
         exp_in     = acc_rescan ? 3'd0 : acc_exp;
         partial_in = acc_rescan ? '0 : acc_partial;
         if (acc_emit) begin
            rsp_valid_in                   = 1'b1;
            rsp_payload_in.code_point      = acc_cp;
            rsp_payload_in.bad_sequence    = acc_bad;
            rsp_payload_in.error_seen      = sticky_ff || acc_bad;
            rsp_payload_in.last_of_run     = 1'b1;
            rsp_payload_in.final_of_string = req_payload.string_end;
            sticky_in = req_payload.string_end ? 1'b0 : (sticky_ff || acc_bad);
         end
      end else if (cmd.rescan_step) begin
         rsp_valid_in                   = 1'b1;
         rsp_payload_in.code_point      = rs_cp;
         rsp_payload_in.bad_sequence    = !rs_fits;
         rsp_payload_in.error_seen      = sticky_ff || !rs_fits;
         rsp_payload_in.last_of_run     = status.rescan_last;
         rsp_payload_in.final_of_string = status.rescan_last;
         sticky_in = status.rescan_last ? 1'b0 : (sticky_ff || !rs_fits);
         count_in  = rs_left;
         case (rs_used)
            2'd1: begin
               pending_in[0] = pending_ff[1];
               pending_in[1] = pending_ff[2];
            end
            2'd2: begin
               pending_in[0] = pending_ff[2];
            end
            default: begin
               pending_in[0] = pending_ff[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         exp_ff       <= 3'd0;
         partial_ff   <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         exp_ff       <= exp_in;
         partial_ff   <= partial_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff     <= pending_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- rtl/core/utf8_byte_stream_decoder.sv -----
// Top level of the UTF-8 byte stream decoder.
// Bytes of a UTF-8 string arrive one per transaction, the last one flagged
// with string_end, and decoded code points leave one per transaction. A byte
// is taken every cycle while the output register is free or draining; a head
// byte starts a sequence of one to four bytes, and the byte that completes it
// gives one code point. When a string ends inside an unfinished sequence, the
// held bytes are decoded again from the front in the rescan state, one result
// per cycle while the output is free, one to three in all; no byte is taken then.
// The sticky error flag clears after the final result of each string.
module utf8_byte_stream_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  utf8d_pkg::utf8d_req_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output utf8d_pkg::utf8d_rsp_type rsp_payload
);

   utf8d_pkg::utf8d_cmd_type    cmd;
   utf8d_pkg::utf8d_status_type status;

   utf8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   utf8d_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ----- dv/utf8_byte_stream_decoder_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the UTF-8 byte stream decoder: directed and random strings against a predictor.
module utf8_byte_stream_decoder_tb;

   localparam int CycleLimit = 200000;
   localparam int RandomItems = 50;
   localparam int MaxReports = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   utf8d_pkg::utf8d_req_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   utf8d_pkg::utf8d_rsp_type rsp_payload;

   // Code points still owed by the block, oldest first.
   utf8d_pkg::utf8d_rsp_type expected_code_points[$];
   // Code points caused by the byte being predicted.
   utf8d_pkg::utf8d_rsp_type byte_results[$];
   logic [7:0]               string_bytes[$];

   // Predictor copy of the decoder state.
   logic [7:0]                    held_bytes[3];
   int                            held_count = 0;
   int                            seq_width = 0;
   logic [utf8d_pkg::CpWidth-1:0] gathered_cp = '0;
   logic                          string_error = 1'b0;

   int mismatch_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int burst_left = 4;
   bit gaps_on = 1'b1;
   int hold_request = 0;

   utf8_byte_stream_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int width_of(input logic [7:0] b);
      int w;
      casez (b)
         8'b0???????: w = utf8d_pkg::WidthOne;
         8'b110?????: w = utf8d_pkg::WidthTwo;
         8'b1110????: w = utf8d_pkg::WidthThree;
         8'b11110???: w = utf8d_pkg::WidthFour;
         default:     w = utf8d_pkg::WidthBad;
      endcase
      return w;
   endfunction

   function automatic logic [utf8d_pkg::CpWidth-1:0] head_payload(input int w,
                                                                 input logic [7:0] b);
      logic [utf8d_pkg::CpWidth-1:0] v;
      v = '0;
      case (w)
         utf8d_pkg::WidthOne:   v[6:0] = b[6:0];
         utf8d_pkg::WidthTwo:   v[4:0] = b[4:0];
         utf8d_pkg::WidthThree: v[3:0] = b[3:0];
         utf8d_pkg::WidthFour:  v[2:0] = b[2:0];
         default:               v = '0;
      endcase
      return v;
   endfunction

   function void note_code_point(input logic [utf8d_pkg::CpWidth-1:0] cp, input logic bad);
      utf8d_pkg::utf8d_rsp_type r;
      if (bad) string_error = 1'b1;
      r.code_point = cp;
      r.bad_sequence = bad;
      r.error_seen = string_error;
      r.last_of_run = 1'b0;
      r.final_of_string = 1'b0;
      byte_results = {byte_results, r};
   endfunction

   task automatic predict_code_points(input logic [7:0] b, input logic fin);
      int                            w;
      int                            i;
      logic [utf8d_pkg::CpWidth-1:0] cp;
      if (held_count == 0) begin
         w = width_of(b);
         if (w == utf8d_pkg::WidthBad) begin
            note_code_point('0, 1'b1);
         end else if (w == utf8d_pkg::WidthOne) begin
            note_code_point(head_payload(w, b), 1'b0);
         end else begin
            held_bytes[0] = b;
            held_count = 1;
            seq_width = w;
            gathered_cp = head_payload(w, b);
         end
      end else begin
         gathered_cp = {gathered_cp[utf8d_pkg::CpWidth-7:0], b[5:0]};
         if (held_count + 1 >= seq_width) begin
            note_code_point(gathered_cp, 1'b0);
            held_count = 0;
            seq_width = 0;
            gathered_cp = '0;
         end else begin
            held_bytes[held_count] = b;
            held_count++;
         end
      end
      // A string that ends inside a sequence is parsed again from the front, sequence by sequence.
      if (fin && held_count > 0) begin
         i = 0;
         while (i < held_count) begin
            w = width_of(held_bytes[i]);
            if (w == utf8d_pkg::WidthBad || i + w > held_count) begin
               note_code_point('0, 1'b1);
               i++;
            end else begin
               cp = head_payload(w, held_bytes[i]);
               for (int j = 1; j < w; j++) begin
                  cp = {cp[utf8d_pkg::CpWidth-7:0], held_bytes[i + j][5:0]};
               end
               note_code_point(cp, 1'b0);
               i += w;
            end
         end
         held_count = 0;
         seq_width = 0;
         gathered_cp = '0;
      end
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last_of_run = 1'b1;
         byte_results[byte_results.size() - 1].final_of_string = fin;
      end
      expected_code_points = {expected_code_points, byte_results};
      byte_results.delete();
      if (fin) string_error = 1'b0;
   endtask

   // Called at a rising edge; returns at the edge that accepts the transaction, or after an idle gap.
   task send_byte(input logic [7:0] b, input logic fin);
      req_valid <= 1'b1;
      req_payload <= '{byte_value: b, string_end: fin};
      @(negedge clock);
      while (req_stall) @(negedge clock);
      predict_code_points(b, fin);
      @(posedge clock);
      items_sent++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task send_string();
      for (int k = 0; k < string_bytes.size(); k++) begin
         send_byte(string_bytes[k], k == string_bytes.size() - 1);
      end
      string_bytes.delete();
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      while (expected_code_points.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] make_head(input int w);
      logic [7:0] b;
      case (w)
         utf8d_pkg::WidthOne:   b = {1'b0, 7'($urandom_range(0, 127))};
         utf8d_pkg::WidthTwo:   b = {3'b110, 5'($urandom_range(0, 31))};
         utf8d_pkg::WidthThree: b = {4'b1110, 4'($urandom_range(0, 15))};
         default:               b = {5'b11110, 3'($urandom_range(0, 7))};
      endcase
      return b;
   endfunction

   function automatic logic [7:0] make_continuation();
      return {2'b10, 6'($urandom_range(0, 63))};
   endfunction

   // Mostly well-formed sequences, with bad heads, cut and sloppy sequences and noise.
   task build_random_string();
      int count;
      int kind;
      int w;
      count = $urandom_range(1, 6);
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            w = $urandom_range(1, 4);
            string_bytes = {string_bytes, make_head(w)};
            repeat (w - 1) string_bytes = {string_bytes, make_continuation()};
         end else if (kind < 70) begin
            if ($urandom_range(0, 1)) string_bytes = {string_bytes, make_continuation()};
            else string_bytes = {string_bytes, {5'b11111, 3'($urandom_range(0, 7))}};
         end else if (kind < 82) begin
            w = $urandom_range(2, 4);
            string_bytes = {string_bytes, make_head(w)};
            repeat ($urandom_range(0, w - 2)) begin
               string_bytes = {string_bytes, make_continuation()};
            end
         end else if (kind < 92) begin
            // Continuation bytes are not validated, so any byte may follow a head.
            w = $urandom_range(2, 4);
            string_bytes = {string_bytes, make_head(w)};
            repeat (w - 1) string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
         end else begin
            string_bytes = {string_bytes, 8'($urandom_range(0, 255))};
         end
      end
   endtask

   task test_single_bytes();
      string_bytes = '{8'h00, 8'h7F};
      send_string();
   endtask

   task test_multibyte();
      string_bytes = '{8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
      send_string();
   endtask

   // The error flag must stick through the string and clear for the next one.
   task test_bad_heads();
      string_bytes = '{8'h80, 8'hFF, 8'hF8};
      send_string();
      string_bytes = '{8'h41};
      send_string();
   endtask

   task test_cut_sequences();
      string_bytes = '{8'hE2};
      send_string();
      string_bytes = '{8'hE2, 8'h82};
      send_string();
      string_bytes = '{8'hF0, 8'h41, 8'hC3};
      send_string();
      string_bytes = '{8'hF0, 8'hC3, 8'hA9};
      send_string();
   endtask

   task test_random_strings();
      int stop_at;
      stop_at = items_sent + RandomItems;
      while (items_sent < stop_at) begin
         build_random_string();
         send_string();
      end
   endtask

   // The receiver holds off while bytes keep coming, so the block must stall its input.
   task test_output_hold();
      int stop_at;
      stop_at = items_sent + 24;
      gaps_on = 1'b0;
      hold_request = 60;
      while (items_sent < stop_at) begin
         build_random_string();
         send_string();
      end
      gaps_on = 1'b1;
   endtask

   task test_pause_until_drained();
      build_random_string();
      send_string();
      wait_for_drain();
      build_random_string();
      send_string();
   endtask

   task report_mismatch(input string what, input utf8d_pkg::utf8d_rsp_type want,
                        input utf8d_pkg::utf8d_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         $display("%s: expected cp=%06h bad=%b err=%b last=%b final=%b",
                  what, want.code_point, want.bad_sequence, want.error_seen,
                  want.last_of_run, want.final_of_string);
         $display("   got cp=%06h bad=%b err=%b last=%b final=%b",
                  got.code_point, got.bad_sequence, got.error_seen,
                  got.last_of_run, got.final_of_string);
      end
   endtask

   // Receiver: random stall phases, some without stalls, plus requested long holds.
   initial begin
      int hold_left;
      int phase_left;
      int stall_pct;
      hold_left = 0;
      phase_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(16, 64);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            phase_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // Outputs are sampled mid-cycle, where they hold the values the next edge will see.
   initial begin
      utf8d_pkg::utf8d_rsp_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_code_points.size() == 0) begin
               report_mismatch("unexpected transaction", '0, rsp_payload);
            end else begin
               want = expected_code_points.pop_front();
               if (want.code_point !== rsp_payload.code_point ||
                   want.bad_sequence !== rsp_payload.bad_sequence ||
                   want.error_seen !== rsp_payload.error_seen ||
                   want.last_of_run !== rsp_payload.last_of_run ||
                   want.final_of_string !== rsp_payload.final_of_string) begin
                  report_mismatch("mismatch", want, rsp_payload);
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_single_bytes();
      test_multibyte();
      test_bad_heads();
      test_cut_sequences();
      test_random_strings();
      test_output_hold();
      test_pause_until_drained();
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_code_points.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_ctrl.sv
rtl/core/utf8d_dp.sv
rtl/core/utf8_byte_stream_decoder.sv
dv/utf8_byte_stream_decoder_tb.sv
